// File: src/assert_macros.svh
// Assertion macros for the RTL; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: src/ldp_pkg.sv
// Shared widths, constants and tables of the segment direction pipeline.
package ldp_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned DeltaW      = 33;
  localparam int unsigned LenW        = 33;
  localparam int unsigned TrigW       = 17;
  localparam int unsigned AngW        = 25;
  localparam int unsigned TolW        = 16;
  localparam int unsigned LenRootW    = 33;  // root of |dx|^2 + |dy|^2
  localparam int unsigned NormRootW   = 48;  // root of normalized sum << 30
  localparam int unsigned QuotW       = 17;  // Q1.15 magnitude incl. saturation bit
  localparam int unsigned NumW        = 63;
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned CordicXW    = 51;
  localparam int unsigned CordicZW    = 33;
  localparam int unsigned FullAngW    = 34;  // angle in 2^-24 degree

  localparam logic [FullAngW-1:0] Deg90  = 34'd1509949440;
  localparam logic [FullAngW-1:0] Deg180 = 34'd3019898880;
  localparam logic [FullAngW-1:0] Deg360 = 34'd6039797760;

  localparam logic [AngW:0]   AngWrap = 26'd23592960;
  localparam logic [AngW-1:0] Ang0    = 25'd0;
  localparam logic [AngW-1:0] Ang90   = 25'd5898240;
  localparam logic [AngW-1:0] Ang180  = 25'd11796480;
  localparam logic [AngW-1:0] Ang270  = 25'd17694720;

  localparam logic [TrigW-1:0] Q15One = 17'd32768;

  // atan(2^-i) in 2^-24 degree
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      5'd24: v = 32'd57;
      5'd25: v = 32'd29;
      5'd26: v = 32'd14;
      5'd27: v = 32'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // leading zero count of a 32-bit word, 0 for a zero word
  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] lz;
    lz = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        lz = 5'(31 - i);
      end
    end
    return lz;
  endfunction

endpackage

// File: src/ldp_delay.sv
// Fixed-depth register delay line for side data.
module ldp_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [Depth];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int i = 1; i < Depth; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[Depth-1];

endmodule

// File: src/ldp_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module ldp_isqrt #(
  parameter int unsigned RootW = 33
) (
  input  logic               clk_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic [RootW-1:0]   root_o,
  output logic [RootW+1:0]   rem_o
);

  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned RemW = RootW + 2;

  logic [RadW-1:0]  rad_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RemW-1:0]  rem_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RadW-1:0]  rad_in;
    logic [RootW-1:0] root_in;
    logic [RemW-1:0]  rem_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
    end

    // bring down the next two radicand bits, try root bit = 1
    assign rem_sh = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in << 2;
      root_q[k] <= {root_in[RootW-2:0], ge};
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
    end
  end

  assign root_o = root_q[RootW-1];
  assign rem_o  = rem_q[RootW-1];

endmodule

// File: src/ldp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ldp_div #(
  parameter int unsigned NumW  = 63,
  parameter int unsigned DivW  = 48,
  parameter int unsigned QuotW = 17
) (
  input  logic             clk_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DivW-1:0]  den_i,
  output logic [QuotW-1:0] quot_o
);

  localparam int unsigned CmpW = DivW + QuotW;

  logic [NumW-1:0]  p_q [QuotW];
  logic [DivW-1:0]  d_q [QuotW];
  logic [QuotW-1:0] q_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int unsigned Sh = QuotW - 1 - k;
    logic [NumW-1:0]  p_in;
    logic [DivW-1:0]  d_in;
    logic [QuotW-1:0] q_in;
    logic [CmpW-1:0]  p_ext;
    logic [CmpW-1:0]  d_sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign p_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign p_in = p_q[k-1];
      assign d_in = d_q[k-1];
      assign q_in = q_q[k-1];
    end

    assign p_ext = CmpW'(p_in);
    assign d_sh  = CmpW'(d_in) << Sh;
    assign ge    = (p_ext >= d_sh);

    always_ff @(posedge clk_i) begin
      p_q[k] <= ge ? NumW'(p_ext - d_sh) : p_in;
      d_q[k] <= d_in;
      q_q[k] <= {q_in[QuotW-2:0], ge};
    end
  end

  assign quot_o = q_q[QuotW-1];

endmodule

// File: src/ldp_cordic.sv
// Pipelined CORDIC vectoring, first-quadrant angle in 2^-24 degree.
module ldp_cordic (
  input  logic                                clk_i,
  input  logic [31:0]                         a_i,
  input  logic [31:0]                         b_i,
  output logic signed [ldp_pkg::CordicZW-1:0] z_o
);

  localparam int unsigned XW = ldp_pkg::CordicXW;
  localparam int unsigned ZW = ldp_pkg::CordicZW;
  localparam int unsigned N  = ldp_pkg::CordicSteps;

  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] at;

    if (k == 0) begin : g_first
      assign x_in = XW'({a_i, 16'b0});
      assign y_in = XW'({b_i, 16'b0});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;
    assign at = ZW'(ldp_pkg::atan_lut(5'(k)));

    always_ff @(posedge clk_i) begin
      if (!y_in[XW-1]) begin
        x_q[k] <= x_in + ys;
        y_q[k] <= y_in - xs;
        z_q[k] <= z_in + at;
      end else begin
        x_q[k] <= x_in - ys;
        y_q[k] <= y_in + xs;
        z_q[k] <= z_in - at;
      end
    end
  end

  assign z_o = z_q[N-1];

endmodule

// File: src/line_direction_params_core.sv
// Top level: segment dx/dy, rounded length, Q1.15 sine/cosine and angle.
//
//  channel   direction  handshake                  payload
//  ------    ---------  -------------------------  ----------------------------
//  command   in         start, busy (always low)   start_x/y_i, end_x/y_i
//  result    out        result_valid_o strobe      delta_x/y_o, seg_length_o,
//                                                  dir_sine/cosine_o, dir_angle_o
//  config    in         cfg_valid_i / cfg_ready_o  cfg_wdata_i (zero tolerance)
//
// One item per clock; every start gives one result_valid_o strobe.
// Latency is set by the 48-stage normalized square root followed by the
// 17-stage divider for sine and cosine; length root and CORDIC run alongside.
// Reset clears the valid pipeline and the tolerance register (to 0).
// The result side cannot stall, so the pipeline never stalls and busy stays low.
`include "assert_macros.svh"

module line_direction_params_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ldp_pkg::CoordW-1:0]     start_x_i,
  input  logic signed [ldp_pkg::CoordW-1:0]     start_y_i,
  input  logic signed [ldp_pkg::CoordW-1:0]     end_x_i,
  input  logic signed [ldp_pkg::CoordW-1:0]     end_y_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [ldp_pkg::TolW-1:0]       cfg_wdata_i,
  output logic                                  result_valid_o,
  output logic signed [ldp_pkg::DeltaW-1:0]     delta_x_o,
  output logic signed [ldp_pkg::DeltaW-1:0]     delta_y_o,
  output logic        [ldp_pkg::LenW-1:0]       seg_length_o,
  output logic signed [ldp_pkg::TrigW-1:0]      dir_sine_o,
  output logic signed [ldp_pkg::TrigW-1:0]      dir_cosine_o,
  output logic        [ldp_pkg::AngW-1:0]       dir_angle_o
);

  localparam int unsigned DW = ldp_pkg::DeltaW;

  // register stage (counted from 1) at which each value is available
  localparam int unsigned TapAb    = 3;
  localparam int unsigned TapSum   = 4;
  localparam int unsigned TapNorm  = 5;
  localparam int unsigned LenDone  = TapSum + ldp_pkg::LenRootW;
  localparam int unsigned NormDone = TapNorm + ldp_pkg::NormRootW;
  localparam int unsigned DivDone  = NormDone + ldp_pkg::QuotW;
  localparam int unsigned CordDone = TapAb + ldp_pkg::CordicSteps;
  localparam int unsigned Lat      = DivDone + 1;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // zero tolerance register
  logic [ldp_pkg::TolW-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // valid bits travel alongside the data
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  assign dx_d = DW'(end_x_i) - DW'(start_x_i);
  assign dy_d = DW'(end_y_i) - DW'(start_y_i);

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  // stage 2: magnitudes and axis classification
  logic [31:0] ax_d, ay_d, ax_q, ay_q;
  logic        horiz_d, vert_d, horiz_q, vert_q;
  assign ax_d    = dx_q[DW-1] ? 32'(-dx_q) : dx_q[31:0];
  assign ay_d    = dy_q[DW-1] ? 32'(-dy_q) : dy_q[31:0];
  assign horiz_d = (ay_d <= 32'(tol_q));
  assign vert_d  = (ax_d <= 32'(tol_q));

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    horiz_q <= horiz_d;
    vert_q  <= vert_d;
  end

  // stage 3: normalize so the larger magnitude has bit 31 set; raw squares
  logic [4:0]  lz;
  logic [31:0] a_q, b_q;
  logic [63:0] sqx_q, sqy_q;
  assign lz = ldp_pkg::lzc32(ax_q | ay_q);

  always_ff @(posedge clk_i) begin
    a_q   <= ax_q << lz;
    b_q   <= ay_q << lz;
    sqx_q <= 64'(ax_q) * 64'(ax_q);
    sqy_q <= 64'(ay_q) * 64'(ay_q);
  end

  // stage 4: raw sum of squares, normalized squares
  logic [64:0] sum_q;
  logic [63:0] a2_q, b2_q;
  always_ff @(posedge clk_i) begin
    sum_q <= 65'(sqx_q) + 65'(sqy_q);
    a2_q  <= 64'(a_q) * 64'(a_q);
    b2_q  <= 64'(b_q) * 64'(b_q);
  end

  // stage 5: normalized sum scaled by 2^30
  logic [2*ldp_pkg::NormRootW-1:0] norm_q;
  always_ff @(posedge clk_i) begin
    norm_q <= (2*ldp_pkg::NormRootW)'(65'(a2_q) + 65'(b2_q)) << 30;
  end

  // length root
  logic [ldp_pkg::LenRootW-1:0] len_root;
  logic [ldp_pkg::LenRootW+1:0] len_rem;
  logic [ldp_pkg::LenW-1:0]     len_rnd, len_dl;

  ldp_isqrt #(.RootW(ldp_pkg::LenRootW)) u_len_sqrt (
    .clk_i  (clk_i),
    .rad_i  ((2*ldp_pkg::LenRootW)'(sum_q)),
    .root_o (len_root),
    .rem_o  (len_rem)
  );

  // round to nearest, ties up: keep root when remainder <= root
  assign len_rnd = (len_rem <= (ldp_pkg::LenRootW+2)'(len_root)) ?
                   len_root : ldp_pkg::LenW'(len_root + 1'b1);

  ldp_delay #(.W(ldp_pkg::LenW), .Depth(DivDone - LenDone)) u_len_dly (
    .clk_i (clk_i),
    .d_i   (len_rnd),
    .q_o   (len_dl)
  );

  // normalized root R
  logic [ldp_pkg::NormRootW-1:0] r_root;
  logic [ldp_pkg::NormRootW+1:0] r_rem;

  ldp_isqrt #(.RootW(ldp_pkg::NormRootW)) u_norm_sqrt (
    .clk_i  (clk_i),
    .rad_i  (norm_q),
    .root_o (r_root),
    .rem_o  (r_rem)
  );

  // normalized magnitudes wait for R
  logic [63:0] ab_dl;
  ldp_delay #(.W(64), .Depth(NormDone - TapAb)) u_ab_dly (
    .clk_i (clk_i),
    .d_i   ({a_q, b_q}),
    .q_o   (ab_dl)
  );

  // |cos| = (a*2^30 + R/2) / R, |sin| likewise with b
  logic [ldp_pkg::NumW-1:0]  num_cos, num_sin;
  logic [ldp_pkg::QuotW-1:0] q_cos, q_sin;
  assign num_cos = ldp_pkg::NumW'({ab_dl[63:32], 30'b0}) + ldp_pkg::NumW'(r_root >> 1);
  assign num_sin = ldp_pkg::NumW'({ab_dl[31:0], 30'b0}) + ldp_pkg::NumW'(r_root >> 1);

  ldp_div #(
    .NumW  (ldp_pkg::NumW),
    .DivW  (ldp_pkg::NormRootW),
    .QuotW (ldp_pkg::QuotW)
  ) u_div_cos (
    .clk_i  (clk_i),
    .num_i  (num_cos),
    .den_i  (r_root),
    .quot_o (q_cos)
  );

  ldp_div #(
    .NumW  (ldp_pkg::NumW),
    .DivW  (ldp_pkg::NormRootW),
    .QuotW (ldp_pkg::QuotW)
  ) u_div_sin (
    .clk_i  (clk_i),
    .num_i  (num_sin),
    .den_i  (r_root),
    .quot_o (q_sin)
  );

  // first-quadrant angle
  logic signed [ldp_pkg::CordicZW-1:0] z_raw, z_dl;

  ldp_cordic u_cordic (
    .clk_i (clk_i),
    .a_i   (a_q),
    .b_i   (b_q),
    .z_o   (z_raw)
  );

  ldp_delay #(.W(ldp_pkg::CordicZW), .Depth(DivDone - CordDone)) u_z_dly (
    .clk_i (clk_i),
    .d_i   (z_raw),
    .q_o   (z_dl)
  );

  // side data to the final stage
  logic [2*DW-1:0] dxy_dl;
  logic [65:0]     mag_dl;

  ldp_delay #(.W(2*DW), .Depth(DivDone - 1)) u_dxy_dly (
    .clk_i (clk_i),
    .d_i   ({dx_q, dy_q}),
    .q_o   (dxy_dl)
  );

  ldp_delay #(.W(66), .Depth(DivDone - 2)) u_mag_dly (
    .clk_i (clk_i),
    .d_i   ({ax_q, ay_q, horiz_q, vert_q}),
    .q_o   (mag_dl)
  );

  // final stage: case select, quadrant, rounding, signs
  logic signed [DW-1:0]             f_dx, f_dy;
  logic [31:0]                      f_ax, f_ay;
  logic                             f_horiz, f_vert;
  logic [ldp_pkg::LenW-1:0]         len_f;
  logic signed [ldp_pkg::TrigW-1:0] sin_f, cos_f;
  logic [ldp_pkg::AngW-1:0]         ang_f;

  assign f_dx    = dxy_dl[2*DW-1:DW];
  assign f_dy    = dxy_dl[DW-1:0];
  assign f_ax    = mag_dl[65:34];
  assign f_ay    = mag_dl[33:2];
  assign f_horiz = mag_dl[1];
  assign f_vert  = mag_dl[0];

  always_comb begin
    logic [ldp_pkg::FullAngW-1:0] zc;
    logic [ldp_pkg::FullAngW-1:0] full;
    logic [ldp_pkg::AngW:0]       ang_r;
    logic [ldp_pkg::TrigW-1:0]    cmag, smag;
    logic                         x_neg, y_neg, x_pos, y_pos;

    x_neg = f_dx[DW-1];
    y_neg = f_dy[DW-1];
    x_pos = !x_neg && (f_dx != '0);
    y_pos = !y_neg && (f_dy != '0);

    if (z_dl[ldp_pkg::CordicZW-1]) begin
      zc = '0;
    end else if (ldp_pkg::FullAngW'(z_dl) > ldp_pkg::Deg90) begin
      zc = ldp_pkg::Deg90;
    end else begin
      zc = ldp_pkg::FullAngW'(z_dl);
    end

    if (x_pos && y_pos) begin
      full = zc;
    end else if (x_neg && y_pos) begin
      full = ldp_pkg::Deg180 - zc;
    end else if (x_neg) begin
      full = ldp_pkg::Deg180 + zc;
    end else begin
      full = ldp_pkg::Deg360 - zc;
    end

    ang_r = (ldp_pkg::AngW+1)'((full + 34'd128) >> 8);
    if (ang_r >= ldp_pkg::AngWrap) begin
      ang_r = ang_r - ldp_pkg::AngWrap;
    end

    cmag = (q_cos > ldp_pkg::Q15One) ? ldp_pkg::Q15One : q_cos;
    smag = (q_sin > ldp_pkg::Q15One) ? ldp_pkg::Q15One : q_sin;

    if (f_horiz) begin
      len_f = ldp_pkg::LenW'(f_ax);
      sin_f = '0;
      cos_f = x_neg ? -$signed(ldp_pkg::Q15One) : $signed(ldp_pkg::Q15One);
      ang_f = x_neg ? ldp_pkg::Ang180 : ldp_pkg::Ang0;
    end else if (f_vert) begin
      len_f = ldp_pkg::LenW'(f_ay);
      cos_f = '0;
      sin_f = y_neg ? -$signed(ldp_pkg::Q15One) : $signed(ldp_pkg::Q15One);
      ang_f = y_neg ? ldp_pkg::Ang270 : ldp_pkg::Ang90;
    end else begin
      len_f = len_dl;
      cos_f = x_neg ? -$signed(cmag) : $signed(cmag);
      sin_f = y_neg ? -$signed(smag) : $signed(smag);
      ang_f = ang_r[ldp_pkg::AngW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    delta_x_o    <= f_dx;
    delta_y_o    <= f_dy;
    seg_length_o <= len_f;
    dir_sine_o   <= sin_f;
    dir_cosine_o <= cos_f;
    dir_angle_o  <= ang_f;
  end

  assign result_valid_o = vld_q[Lat-1];

  // checks
  logic signed [DW-1:0] in_dx;
  assign in_dx = dx_d;

  `ASSERT_CLK(a_res_from_item, clk_i, rst_ni, result_valid_o |-> $past(accept, Lat), "result without item")
  `ASSERT_CLK(a_dx_aligned, clk_i, rst_ni, result_valid_o |-> (delta_x_o == $past(in_dx, Lat)), "dx misaligned")
  `ASSERT_NEVER(a_ang_range, clk_i, rst_ni, result_valid_o && (26'(dir_angle_o) >= ldp_pkg::AngWrap), "angle not wrapped")
  `ASSERT_CLK(a_zero_len, clk_i, rst_ni, (result_valid_o && (seg_length_o == '0)) |-> ((dir_angle_o == ldp_pkg::Ang0) && (dir_sine_o == '0)), "zero length not horizontal")

endmodule
